// ----- rtl/frt_pkg.sv -----
// Shared types and constants for the fragment reassembly tracker.
// No dependencies.
package frt_pkg;

  localparam int unsigned NumSlots      = 16;
  localparam int unsigned SlotW         = $clog2(NumSlots);
  localparam int unsigned MaxFragments  = 64;
  localparam int unsigned IdxW          = $clog2(MaxFragments);
  localparam int unsigned TotW          = IdxW + 1;
  localparam int unsigned HeaderBytes   = 6;
  localparam logic [31:0] TimeoutReset  = 32'd1000;

  localparam logic [2:0] ST_REJECTED  = 3'd0;
  localparam logic [2:0] ST_SINGLE    = 3'd1;
  localparam logic [2:0] ST_STORED    = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_MISMATCH  = 3'd4;
  localparam logic [2:0] ST_COMPLETE  = 3'd5;
  localparam logic [2:0] ST_SWEEP     = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic lookup;    // register hit / free / oldest search results
    logic update;    // apply table update, build result
  } frt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dummy_ok;
  } frt_sts_t;

endpackage

// ----- rtl/frt_datapath.sv -----
// Datapath of the fragment reassembly tracker: slot table, searches, result.
// Depends on frt_pkg.
module frt_datapath import frt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  frt_cmd_t    cmd,
  output frt_sts_t    sts,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_action,
  input  logic [15:0] in_message_id,
  input  logic [15:0] in_frag_index,
  input  logic [15:0] in_frag_total,
  input  logic [15:0] in_packet_len,
  input  logic [31:0] in_now_ms,
  output logic [2:0]  res_status,
  output logic [3:0]  res_slot,
  output logic        res_evicted,
  output logic [4:0]  res_expired
);

  logic [31:0]             timeout_r;
  logic                    act_r;
  logic [15:0]             msg_r, idx_r, tot_r, len_r;
  logic [31:0]             now_r;

  logic [NumSlots-1:0]     valid_r;
  logic [15:0]             emsg_r   [NumSlots];
  logic [TotW-1:0]         etot_r   [NumSlots];
  logic [TotW-1:0]         ecnt_r   [NumSlots];
  logic [MaxFragments-1:0] epres_r  [NumSlots];
  logic [31:0]             efirst_r [NumSlots];

  // lookup stage registers
  logic                    hit_r, free_r, reject_r;
  logic [SlotW-1:0]        hit_slot_r, free_slot_r, old_slot_r;
  logic [NumSlots-1:0]     expire_r;

  logic                    hit_c, free_c;
  logic [SlotW-1:0]        hit_slot_c, free_slot_c;
  logic [NumSlots-1:0]     expire_c;

  assign sts.dummy_ok = 1'b1;

  always_comb begin
    hit_c = 1'b0; hit_slot_c = '0;
    free_c = 1'b0; free_slot_c = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (valid_r[i] && emsg_r[i] == msg_r) begin
        hit_c = 1'b1; hit_slot_c = SlotW'(i);
      end
      if (!valid_r[i]) begin
        free_c = 1'b1; free_slot_c = SlotW'(i);
      end
      expire_c[i] = valid_r[i] && ((now_r - efirst_r[i]) > timeout_r);
    end
  end

  // oldest search: registered tree, two levels of four
  logic [SlotW-1:0] grp_slot_r [4];
  logic [3:0]       grp_v_r;
  logic [SlotW-1:0] grp_slot_c [4];
  logic [3:0]       grp_v_c;
  logic [SlotW-1:0] old_c;
  logic             old_v;

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp_v_c[g] = 1'b0; grp_slot_c[g] = '0;
      for (int k = 0; k < NumSlots / 4; k++) begin
        if (valid_r[g*4+k] && (!grp_v_c[g] ||
            efirst_r[g*4+k] < efirst_r[grp_slot_c[g]])) begin
          grp_v_c[g] = 1'b1; grp_slot_c[g] = SlotW'(g*4+k);
        end
      end
    end
    old_v = 1'b0; old_c = '0;
    for (int g = 0; g < 4; g++) begin
      if (grp_v_r[g] && (!old_v || efirst_r[grp_slot_r[g]] < efirst_r[old_c])) begin
        old_v = 1'b1; old_c = grp_slot_r[g];
      end
    end
  end

  logic [SlotW-1:0] s_c;
  logic [IdxW-1:0]  ix;
  assign ix  = idx_r[IdxW-1:0];
  assign s_c = free_r ? free_slot_r : old_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TimeoutReset;
      valid_r   <= '0;
    end else begin
      if (cfg_we) timeout_r <= cfg_wdata;
      if (cmd.load) begin
        act_r <= in_action; msg_r <= in_message_id; idx_r <= in_frag_index;
        tot_r <= in_frag_total; len_r <= in_packet_len; now_r <= in_now_ms;
      end
      if (cmd.lookup) begin
        hit_r <= hit_c; hit_slot_r <= hit_slot_c;
        free_r <= free_c; free_slot_r <= free_slot_c;
        expire_r <= expire_c;
        grp_slot_r <= grp_slot_c; grp_v_r <= grp_v_c;
        reject_r <= (len_r < 16'(HeaderBytes)) || (tot_r == 16'd0) ||
                    (tot_r > 16'(MaxFragments)) || (idx_r >= tot_r);
      end
      if (cmd.update) begin
        if (act_r) begin
          res_status  <= ST_SWEEP;
          res_slot    <= '0;
          res_evicted <= 1'b0;
          res_expired <= 5'($countones(expire_r));
          valid_r     <= valid_r & ~expire_r;
        end else if (reject_r) begin
          res_status  <= ST_REJECTED;
          res_slot    <= '0;
          res_evicted <= 1'b0;
          res_expired <= '0;
        end else if (hit_r) begin
          res_slot    <= 4'(hit_slot_r);
          res_evicted <= 1'b0;
          res_expired <= '0;
          if (etot_r[hit_slot_r] != tot_r[TotW-1:0]) begin
            res_status <= ST_MISMATCH; valid_r[hit_slot_r] <= 1'b0;
          end else if (epres_r[hit_slot_r][ix]) begin
            res_status <= ST_DUPLICATE;
          end else begin
            epres_r[hit_slot_r][ix] <= 1'b1;
            ecnt_r[hit_slot_r] <= ecnt_r[hit_slot_r] + 1'b1;
            if (ecnt_r[hit_slot_r] + 1'b1 >= etot_r[hit_slot_r]) begin
              res_status <= ST_COMPLETE; valid_r[hit_slot_r] <= 1'b0;
            end else begin
              res_status <= ST_STORED;
            end
          end
        end else if (tot_r == 16'd1) begin
          res_status  <= ST_SINGLE;
          res_slot    <= '0;
          res_evicted <= 1'b0;
          res_expired <= '0;
        end else begin
          // new entry, total >= 2 so first fragment never completes
          res_slot    <= 4'(s_c);
          res_evicted <= !free_r;
          res_expired <= '0;
          res_status  <= ST_STORED;
          valid_r[s_c]  <= 1'b1;
          emsg_r[s_c]   <= msg_r;
          etot_r[s_c]   <= tot_r[TotW-1:0];
          ecnt_r[s_c]   <= TotW'(1);
          efirst_r[s_c] <= now_r;
          epres_r[s_c]  <= MaxFragments'(1) << ix;
        end
      end
    end
  end

endmodule

// ----- rtl/frt_ctrl.sv -----
// Controller of the fragment reassembly tracker: handshake and sequencing.
// Depends on frt_pkg.
module frt_ctrl import frt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  frt_sts_t sts,
  output frt_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_TREE, S_UPD} state_t;
  state_t state_r;
  logic   out_valid_r;

  // update waits until the result register is free or being read
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.lookup = (state_r == S_LOOK);
  assign cmd.update = (state_r == S_UPD) && (!out_valid_r || out_ready) && sts.dummy_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (cmd.load) state_r <= S_LOOK;
        S_LOOK: state_r <= S_TREE;
        S_TREE: state_r <= S_UPD;
        S_UPD: if (cmd.update) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/fragment_reassembly_tracker.sv -----
// Top level of the fragment reassembly tracker.
// Depends on frt_pkg, frt_ctrl, frt_datapath.
//
// Input channel (in_valid/in_ready) carries a fragment header or a sweep
// tick; result channel (out_valid/out_ready) returns one result per
// transaction: status, slot, evicted, expired_count.
// cfg_we/cfg_wdata write timeout_ms; write only while idle.
// Each transaction passes through the load, lookup, oldest-search tree
// and update steps of the controller in order, and a new transaction is
// accepted only after the update step; the slot table has 16 entries.
// A result waits in the output register while the next transaction is
// accepted and processed; if the receiver still stalls at the update
// step, in_ready stays low until the result is taken.
// Reset (rst_n, synchronous) empties the table at once and sets
// timeout_ms to 1000; no clearing pass is needed.
module fragment_reassembly_tracker import frt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [15:0] in_message_id,
  input  logic [15:0] in_frag_index,
  input  logic [15:0] in_frag_total,
  input  logic [15:0] in_packet_len,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot,
  output logic        out_evicted,
  output logic [4:0]  out_expired_count
);

  frt_cmd_t cmd;
  frt_sts_t sts;
  logic     rdy_c;

  frt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready(rdy_c), .out_valid, .out_ready,
    .sts, .cmd
  );
  assign in_ready = rdy_c;

  frt_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_wdata,
    .in_action, .in_message_id, .in_frag_index, .in_frag_total,
    .in_packet_len, .in_now_ms,
    .res_status(out_status), .res_slot(out_slot),
    .res_evicted(out_evicted), .res_expired(out_expired_count)
  );

endmodule
